// ===== rtl/mclk_pkg.sv =====
package mclk_pkg;

    // Widths of the request and result fields.
    localparam int ACTION_W = 1;
    localparam int LOAD_X_W = 19;
    localparam int LOAD_Y_W = 22;
    localparam int LOAD_Z_W = 23;
    localparam int NOW_X_W  = 19;
    localparam int NOW_Y_W  = 22;
    localparam int NOW_Z_W  = 23;

    // Stream data buses, packed from bit 0 and padded to whole bytes.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    // Widest register the design supports.
    localparam int LEN_MAX = 32;

    // Configuration port.
    localparam int TAP_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_TAP_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_TAP_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TAP_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TAP_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_TAP_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_TAP_SECOND = 3'd5;

    localparam logic [TAP_W-1:0] TAP_FIRST_RESET  = 5'd0;
    localparam logic [TAP_W-1:0] TAP_SECOND_RESET = 5'd1;

    // Values of the action field.
    localparam logic [ACTION_W-1:0] ACTION_LOAD = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_STEP = 1'b1;

    // Default register lengths and clock bit positions (counted from the top bit).
    localparam int LEN_X_DEFAULT       = 19;
    localparam int LEN_Y_DEFAULT       = 22;
    localparam int LEN_Z_DEFAULT       = 23;
    localparam int CLOCK_POS_X_DEFAULT = 10;
    localparam int CLOCK_POS_Y_DEFAULT = 11;
    localparam int CLOCK_POS_Z_DEFAULT = 12;

    // Per-register control for one accepted request.
    typedef struct packed {
        logic load;
        logic shift;
    } lfsr_ctrl_t;

endpackage

// ===== rtl/majority_clocked_lfsr_keystream_top.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: load_x, load_y, load_z
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: key_bit, now_x, now_y, now_z
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data (feedback taps)
//
// The three registers update at the edge that accepts a request and the result is valid
// from the next cycle, so a request can be taken every cycle while the results are taken.
// The result is read straight from the three registers, which hold while it waits.
// A new request is accepted whenever no result is pending or the pending one is taken in
// the same cycle. Reset clears the registers and the taps go to 0 and 1 for each register.
// The configuration port is always ready.
module majority_clocked_lfsr_keystream_top #(
    parameter int LEN_X       = mclk_pkg::LEN_X_DEFAULT,
    parameter int LEN_Y       = mclk_pkg::LEN_Y_DEFAULT,
    parameter int LEN_Z       = mclk_pkg::LEN_Z_DEFAULT,
    parameter int CLOCK_POS_X = mclk_pkg::CLOCK_POS_X_DEFAULT,
    parameter int CLOCK_POS_Y = mclk_pkg::CLOCK_POS_Y_DEFAULT,
    parameter int CLOCK_POS_Z = mclk_pkg::CLOCK_POS_Z_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // load_x [18:0], load_y [40:19], load_z [63:41]
    input  logic [mclk_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // action [0]
    input  logic [mclk_pkg::ACTION_W-1:0]  s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // key_bit [0], now_x [19:1], now_y [41:20], now_z [64:42], zeros [71:65]
    output logic [mclk_pkg::M_DATA_W-1:0]  m_axis_tdata,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mclk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mclk_pkg::TAP_W-1:0]     cfg_data
);

    localparam int LX = mclk_pkg::LOAD_X_W;
    localparam int LY = mclk_pkg::LOAD_Y_W;
    localparam int LZ = mclk_pkg::LOAD_Z_W;

    // Request fields.
    logic [LX-1:0] load_x;
    logic [LY-1:0] load_y;
    logic [LZ-1:0] load_z;
    logic          accept;
    logic          is_step;

    // Feedback tap registers.
    logic [mclk_pkg::TAP_W-1:0] x_tap_first_reg;
    logic [mclk_pkg::TAP_W-1:0] x_tap_second_reg;
    logic [mclk_pkg::TAP_W-1:0] y_tap_first_reg;
    logic [mclk_pkg::TAP_W-1:0] y_tap_second_reg;
    logic [mclk_pkg::TAP_W-1:0] z_tap_first_reg;
    logic [mclk_pkg::TAP_W-1:0] z_tap_second_reg;

    // Register contents and clock bits.
    logic [LEN_X-1:0] x_state;
    logic [LEN_Y-1:0] y_state;
    logic [LEN_Z-1:0] z_state;
    logic             cx;
    logic             cy;
    logic             cz;
    logic             majority;

    // Load values and results widened to the largest supported length.
    logic [mclk_pkg::LEN_MAX-1:0] x_load_wide;
    logic [mclk_pkg::LEN_MAX-1:0] y_load_wide;
    logic [mclk_pkg::LEN_MAX-1:0] z_load_wide;
    logic [mclk_pkg::LEN_MAX-1:0] x_now_wide;
    logic [mclk_pkg::LEN_MAX-1:0] y_now_wide;
    logic [mclk_pkg::LEN_MAX-1:0] z_now_wide;

    mclk_pkg::lfsr_ctrl_t x_ctrl;
    mclk_pkg::lfsr_ctrl_t y_ctrl;
    mclk_pkg::lfsr_ctrl_t z_ctrl;

    logic out_valid_reg;
    logic out_valid_next;
    logic key_bit;

    // ------------------------------------------------------------------
    // Request side. The result comes straight from the registers, so a
    // request may only land when the previous result has gone or is going.
    // ------------------------------------------------------------------
    assign load_x = s_axis_tdata[LX-1:0];
    assign load_y = s_axis_tdata[LX+LY-1:LX];
    assign load_z = s_axis_tdata[LX+LY+LZ-1:LX+LY];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_step       = (s_axis_tuser == mclk_pkg::ACTION_STEP);

    // A load wider than a register is cut to the register's length.
    assign x_load_wide = mclk_pkg::LEN_MAX'(load_x);
    assign y_load_wide = mclk_pkg::LEN_MAX'(load_y);
    assign z_load_wide = mclk_pkg::LEN_MAX'(load_z);

    // ------------------------------------------------------------------
    // Majority clocking: a register moves when its clock bit agrees with
    // the majority of the clock bits of all three registers.
    // ------------------------------------------------------------------
    assign majority = (cx & cy) | (cx & cz) | (cy & cz);

    always_comb
    begin
        x_ctrl.load  = accept && !is_step;
        y_ctrl.load  = accept && !is_step;
        z_ctrl.load  = accept && !is_step;
        x_ctrl.shift = accept && is_step && (cx == majority);
        y_ctrl.shift = accept && is_step && (cy == majority);
        z_ctrl.shift = accept && is_step && (cz == majority);
    end

    mclk_lfsr #(
        .LEN       (LEN_X),
        .CLOCK_POS (CLOCK_POS_X)
    ) u_lfsr_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (x_ctrl),
        .load_val   (x_load_wide[LEN_X-1:0]),
        .tap_first  (x_tap_first_reg),
        .tap_second (x_tap_second_reg),
        .state      (x_state),
        .clock_bit  (cx)
    );

    mclk_lfsr #(
        .LEN       (LEN_Y),
        .CLOCK_POS (CLOCK_POS_Y)
    ) u_lfsr_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (y_ctrl),
        .load_val   (y_load_wide[LEN_Y-1:0]),
        .tap_first  (y_tap_first_reg),
        .tap_second (y_tap_second_reg),
        .state      (y_state),
        .clock_bit  (cy)
    );

    mclk_lfsr #(
        .LEN       (LEN_Z),
        .CLOCK_POS (CLOCK_POS_Z)
    ) u_lfsr_z (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (z_ctrl),
        .load_val   (z_load_wide[LEN_Z-1:0]),
        .tap_first  (z_tap_first_reg),
        .tap_second (z_tap_second_reg),
        .state      (z_state),
        .clock_bit  (cz)
    );

    // ------------------------------------------------------------------
    // Result side. Valid is set by each accepted request and cleared when
    // the result is taken with nothing new arriving.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign x_now_wide = mclk_pkg::LEN_MAX'(x_state);
    assign y_now_wide = mclk_pkg::LEN_MAX'(y_state);
    assign z_now_wide = mclk_pkg::LEN_MAX'(z_state);
    assign key_bit    = x_state[0] ^ y_state[0] ^ z_state[0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (mclk_pkg::M_DATA_W - 1 - mclk_pkg::NOW_X_W - mclk_pkg::NOW_Y_W
            - mclk_pkg::NOW_Z_W)'(0),
        z_now_wide[mclk_pkg::NOW_Z_W-1:0],
        y_now_wide[mclk_pkg::NOW_Y_W-1:0],
        x_now_wide[mclk_pkg::NOW_X_W-1:0],
        key_bit
    };

    // ------------------------------------------------------------------
    // Configuration. Writes to indexes beyond the tap list are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_tap_first_reg  <= mclk_pkg::TAP_FIRST_RESET;
            x_tap_second_reg <= mclk_pkg::TAP_SECOND_RESET;
            y_tap_first_reg  <= mclk_pkg::TAP_FIRST_RESET;
            y_tap_second_reg <= mclk_pkg::TAP_SECOND_RESET;
            z_tap_first_reg  <= mclk_pkg::TAP_FIRST_RESET;
            z_tap_second_reg <= mclk_pkg::TAP_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mclk_pkg::REG_X_TAP_FIRST:  x_tap_first_reg  <= cfg_data;
                mclk_pkg::REG_X_TAP_SECOND: x_tap_second_reg <= cfg_data;
                mclk_pkg::REG_Y_TAP_FIRST:  y_tap_first_reg  <= cfg_data;
                mclk_pkg::REG_Y_TAP_SECOND: y_tap_second_reg <= cfg_data;
                mclk_pkg::REG_Z_TAP_FIRST:  z_tap_first_reg  <= cfg_data;
                mclk_pkg::REG_Z_TAP_SECOND: z_tap_second_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/mclk_lfsr.sv =====
// One right-shifting feedback register with a load port and a clock bit tap.
module mclk_lfsr #(
    parameter int LEN       = mclk_pkg::LEN_X_DEFAULT,
    parameter int CLOCK_POS = mclk_pkg::CLOCK_POS_X_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mclk_pkg::lfsr_ctrl_t       ctrl,
    input  logic [LEN-1:0]             load_val,
    input  logic [mclk_pkg::TAP_W-1:0] tap_first,
    input  logic [mclk_pkg::TAP_W-1:0] tap_second,
    output logic [LEN-1:0]             state,
    output logic                       clock_bit
);

    localparam int  IDX_W     = (LEN > 1) ? $clog2(LEN) : 1;
    localparam bit  CLK_VALID = (CLOCK_POS < LEN);
    localparam int  CLK_BIT   = CLK_VALID ? (LEN - 1 - CLOCK_POS) : 0;

    logic [LEN-1:0] lfsr_reg;
    logic [LEN-1:0] lfsr_next;
    logic [LEN-1:0] rev;
    logic           bit_first;
    logic           bit_second;
    logic           feedback;

    // Taps count from the top bit, so index a bit-reversed copy.
    always_comb
    begin
        for (int i = 0; i < LEN; i++)
        begin
            rev[i] = lfsr_reg[LEN-1-i];
        end
    end

    // A tap at or beyond the register length reads as zero.
    assign bit_first  = ({1'b0, tap_first} < (mclk_pkg::TAP_W+1)'(LEN))
                        ? rev[tap_first[IDX_W-1:0]] : 1'b0;
    assign bit_second = ({1'b0, tap_second} < (mclk_pkg::TAP_W+1)'(LEN))
                        ? rev[tap_second[IDX_W-1:0]] : 1'b0;
    assign feedback   = bit_first ^ bit_second;

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            lfsr_next = load_val;
        end
        else if (ctrl.shift)
        begin
            lfsr_next = {feedback, lfsr_reg[LEN-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= '0;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign state     = lfsr_reg;
    assign clock_bit = CLK_VALID ? lfsr_reg[CLK_BIT] : 1'b0;

endmodule

// ===== test/tb_majority_clocked_lfsr_keystream_top.sv =====
module tb_majority_clocked_lfsr_keystream_top;
    import mclk_pkg::*;

    // Run limits and shape of the random part.
    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int unsigned DRAIN_LIMIT       = 5000;
    localparam int unsigned HOLD_CYCLES       = 120;
    localparam int unsigned TAP_SETTINGS      = 8;
    localparam int unsigned ITEMS_PER_SETTING = 204;
    localparam int unsigned REPORT_LIMIT      = 10;

    // Indexes past the last tap register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    // A tap this far from the top lies outside every register and reads as zero.
    localparam logic [TAP_W-1:0]     TAP_BEYOND       = 5'd31;

    localparam logic [LOAD_X_W-1:0] X_ONES = '1;
    localparam logic [LOAD_Y_W-1:0] Y_ONES = '1;
    localparam logic [LOAD_Z_W-1:0] Z_ONES = '1;

    // One result as it appears on m_axis_tdata, key bit in bit 0.
    typedef struct packed {
        logic [NOW_Z_W-1:0] now_z;
        logic [NOW_Y_W-1:0] now_y;
        logic [NOW_X_W-1:0] now_x;
        logic               key_bit;
    } keystream_view_t;

    localparam int VIEW_W = $bits(keystream_view_t);

    typedef enum logic [1:0] {ROW_LOAD, ROW_STEP, ROW_TAP} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [LOAD_X_W-1:0]   x;
        logic [LOAD_Y_W-1:0]   y;
        logic [LOAD_Z_W-1:0]   z;
        logic [CFG_IDX_W-1:0]  index;
        logic [TAP_W-1:0]      value;
        bit                    typed;
        keystream_view_t       want;
    } directed_row_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_JITTER, SINK_TOGGLE, SINK_CHOKE} sink_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;
    logic [ACTION_W-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TAP_W-1:0]     cfg_data;

    // Private copy of the three shift registers and the six taps.
    logic [NOW_X_W-1:0] x_state;
    logic [NOW_Y_W-1:0] y_state;
    logic [NOW_Z_W-1:0] z_state;
    logic [TAP_W-1:0]   tap_cfg [0:5];

    // Results owed by the block, oldest first.
    keystream_view_t keystream_due [$];
    directed_row_t   directed_rows [$];

    int unsigned failures     = 0;
    int unsigned results_seen = 0;
    int unsigned loads_sent   = 0;
    int unsigned steps_sent   = 0;
    int unsigned tap_writes   = 0;
    int unsigned cycles       = 0;

    // Sender pacing.
    int unsigned burst_left  = 0;
    int unsigned steady_left = 0;

    // Receiver pattern; the stimulus asks for a long hold by bumping hold_orders.
    int unsigned hold_orders = 0;
    int unsigned holds_seen  = 0;
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    sink_mode_t  sink_mode   = SINK_OPEN;

    majority_clocked_lfsr_keystream_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bit pos counted down from the top of a len-bit register; outside it reads zero.
    function automatic logic bit_from_top(logic [LEN_MAX-1:0] r, int len,
                                          logic [TAP_W-1:0] pos);
        if (int'(pos) >= len)
            return 1'b0;
        return r[len - 1 - int'(pos)];
    endfunction

    // Right shift with the top bit refilled from the two taps, both read first.
    function automatic logic [LEN_MAX-1:0] lfsr_shift(logic [LEN_MAX-1:0] r, int len,
                                                      logic [TAP_W-1:0] tap_a,
                                                      logic [TAP_W-1:0] tap_b);
        logic fill;
        fill = bit_from_top(r, len, tap_a) ^ bit_from_top(r, len, tap_b);
        r = r >> 1;
        r[len - 1] = fill;
        return r;
    endfunction

    // Applies one request to the private registers and returns the result it owes.
    function automatic keystream_view_t clock_keystream(logic [ACTION_W-1:0] action,
                                                        logic [LOAD_X_W-1:0] lx,
                                                        logic [LOAD_Y_W-1:0] ly,
                                                        logic [LOAD_Z_W-1:0] lz);
        logic                cx;
        logic                cy;
        logic                cz;
        logic                vote;
        logic [LEN_MAX-1:0]  wide;
        keystream_view_t     v;
        if (action == ACTION_LOAD)
        begin
            x_state = lx;
            y_state = ly;
            z_state = lz;
        end
        else
        begin
            cx = bit_from_top(LEN_MAX'(x_state), LEN_X_DEFAULT, TAP_W'(CLOCK_POS_X_DEFAULT));
            cy = bit_from_top(LEN_MAX'(y_state), LEN_Y_DEFAULT, TAP_W'(CLOCK_POS_Y_DEFAULT));
            cz = bit_from_top(LEN_MAX'(z_state), LEN_Z_DEFAULT, TAP_W'(CLOCK_POS_Z_DEFAULT));
            vote = (cx & cy) | (cx & cz) | (cy & cz);
            // Only the registers that agree with the majority move.
            if (cx == vote)
            begin
                wide = lfsr_shift(LEN_MAX'(x_state), LEN_X_DEFAULT,
                                  tap_cfg[REG_X_TAP_FIRST], tap_cfg[REG_X_TAP_SECOND]);
                x_state = wide[NOW_X_W-1:0];
            end
            if (cy == vote)
            begin
                wide = lfsr_shift(LEN_MAX'(y_state), LEN_Y_DEFAULT,
                                  tap_cfg[REG_Y_TAP_FIRST], tap_cfg[REG_Y_TAP_SECOND]);
                y_state = wide[NOW_Y_W-1:0];
            end
            if (cz == vote)
            begin
                wide = lfsr_shift(LEN_MAX'(z_state), LEN_Z_DEFAULT,
                                  tap_cfg[REG_Z_TAP_FIRST], tap_cfg[REG_Z_TAP_SECOND]);
                z_state = wide[NOW_Z_W-1:0];
            end
        end
        v.now_x   = x_state;
        v.now_y   = y_state;
        v.now_z   = z_state;
        v.key_bit = x_state[0] ^ y_state[0] ^ z_state[0];
        return v;
    endfunction

    function automatic logic [TAP_W-1:0] pick_tap(int len, bit any_value);
        int unsigned r;
        r = any_value ? $urandom_range(0, 31) : $urandom_range(0, len - 1);
        return r[TAP_W-1:0];
    endfunction

    task automatic add_item(row_kind_t kind, logic [LOAD_X_W-1:0] x, logic [LOAD_Y_W-1:0] y,
                            logic [LOAD_Z_W-1:0] z, bit typed = 1'b0,
                            keystream_view_t want = '0);
        directed_row_t r;
        r.kind  = kind;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.index = '0;
        r.value = '0;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_tap(logic [CFG_IDX_W-1:0] index, logic [TAP_W-1:0] value);
        directed_row_t r;
        r.kind  = ROW_TAP;
        r.x     = '0;
        r.y     = '0;
        r.z     = '0;
        r.index = index;
        r.value = value;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    // Presents one request and waits for it to be taken. The valid stays high afterwards,
    // so the caller either offers the next request or lowers it at the next falling edge.
    task automatic offer(logic [ACTION_W-1:0] action, logic [LOAD_X_W-1:0] lx,
                         logic [LOAD_Y_W-1:0] ly, logic [LOAD_Z_W-1:0] lz,
                         bit typed, keystream_view_t want);
        keystream_view_t predicted;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lz, ly, lx};
        s_axis_tuser  <= action;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = clock_keystream(action, lx, ly, lz);
        keystream_due.push_back(typed ? want : predicted);
        if (action == ACTION_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    // Ends a burst now and then with a short gap in the request stream.
    task automatic pace();
        int unsigned gap;
        if (burst_left != 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1)
            @(negedge clk);
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (keystream_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tap(logic [CFG_IDX_W-1:0] index, logic [TAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index <= REG_Z_TAP_SECOND)
            tap_cfg[index] = value;
        tap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: switches between randomly chosen ready patterns, and on request from the
    // stimulus refuses results for a long stretch so the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_orders != holds_seen)
        begin
            holds_seen = hold_orders;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (sink_mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_JITTER: m_axis_tready <= ($urandom_range(0, 2) != 0);
                SINK_TOGGLE: m_axis_tready <= !m_axis_tready;
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Every result taken is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        keystream_view_t got;
        keystream_view_t want;
        logic [M_DATA_W-VIEW_W-1:0] pad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[VIEW_W-1:0];
            pad = m_axis_tdata[M_DATA_W-1:VIEW_W];
            results_seen++;
            if (keystream_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: key %0b x %h y %h z %h",
                             got.key_bit, got.now_x, got.now_y, got.now_z);
            end
            else
            begin
                want = keystream_due.pop_front();
                if (got.key_bit !== want.key_bit || got.now_x !== want.now_x ||
                    got.now_y !== want.now_y || got.now_z !== want.now_z || pad !== '0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("result %0d: expected key %0b x %h y %h z %h",
                                 results_seen, want.key_bit, want.now_x, want.now_y,
                                 want.now_z);
                        $display("    got key %0b x %h y %h z %h pad %h",
                                 got.key_bit, got.now_x, got.now_y, got.now_z, pad);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycles, keystream_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int unsigned         setting;
        int unsigned         n;
        int unsigned         waited;
        int unsigned         rnd;
        logic [ACTION_W-1:0] action;
        logic [LOAD_X_W-1:0] lx;
        logic [LOAD_Y_W-1:0] ly;
        logic [LOAD_Z_W-1:0] lz;
        logic [TAP_W-1:0]    xf;
        logic [TAP_W-1:0]    xs;
        logic [TAP_W-1:0]    yf;
        logic [TAP_W-1:0]    ys;
        logic [TAP_W-1:0]    zf;
        logic [TAP_W-1:0]    zs;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACTION_LOAD;
        cfg_valid     = 1'b0;
        cfg_index     = REG_X_TAP_FIRST;
        cfg_data      = '0;

        x_state = '0;
        y_state = '0;
        z_state = '0;
        tap_cfg[REG_X_TAP_FIRST]  = TAP_FIRST_RESET;
        tap_cfg[REG_X_TAP_SECOND] = TAP_SECOND_RESET;
        tap_cfg[REG_Y_TAP_FIRST]  = TAP_FIRST_RESET;
        tap_cfg[REG_Y_TAP_SECOND] = TAP_SECOND_RESET;
        tap_cfg[REG_Z_TAP_FIRST]  = TAP_FIRST_RESET;
        tap_cfg[REG_Z_TAP_SECOND] = TAP_SECOND_RESET;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sweep. Out of reset the clock bits of all three registers are zero,
        // so every register shifts, but with the default taps a zero register stays zero.
        add_item(ROW_STEP, '0, '0, '0, 1'b1, '0);
        add_item(ROW_LOAD, X_ONES, Y_ONES, Z_ONES, 1'b1, {Z_ONES, Y_ONES, X_ONES, 1'b1});
        add_item(ROW_STEP, '0, '0, '0);
        // Load fields carried on a step are ignored.
        add_item(ROW_STEP, X_ONES, Y_ONES, Z_ONES);
        add_item(ROW_LOAD, '0, '0, '0, 1'b1, '0);
        add_item(ROW_LOAD, 19'h55555, 22'h2AAAAA, 23'h555555);
        add_item(ROW_STEP, '0, '0, '0);
        // Only x has its clock bit set, so x is outvoted and holds.
        add_item(ROW_LOAD, 19'h00100, '0, '0);
        add_item(ROW_STEP, '0, '0, '0);
        // y and z vote one, x votes zero and holds.
        add_item(ROW_LOAD, 19'h00001, 22'h000401, 23'h000400);
        add_item(ROW_STEP, '0, '0, '0);
        // A tap outside the register, taps on the bottom bit, and the spare indexes.
        add_tap(REG_X_TAP_FIRST, TAP_BEYOND);
        add_tap(REG_Y_TAP_SECOND, 5'd21);
        add_tap(REG_Z_TAP_FIRST, 5'd22);
        add_tap(CFG_IDX_SPARE_LO, TAP_BEYOND);
        add_tap(CFG_IDX_SPARE_HI, '0);
        add_item(ROW_LOAD, X_ONES, Y_ONES, Z_ONES, 1'b1, {Z_ONES, Y_ONES, X_ONES, 1'b1});
        add_item(ROW_STEP, '0, '0, '0);
        add_item(ROW_STEP, '0, '0, '0);
        add_item(ROW_STEP, '0, '0, '0);
        add_item(ROW_LOAD, 19'h40000, 22'h200000, 23'h400000);
        add_item(ROW_STEP, '0, '0, '0);
        add_item(ROW_STEP, '0, '0, '0);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_TAP:
                begin
                    drain_results();
                    write_tap(directed_rows[i].index, directed_rows[i].value);
                end
                default:
                    offer(directed_rows[i].kind == ROW_LOAD ? ACTION_LOAD : ACTION_STEP,
                          directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                          directed_rows[i].typed, directed_rows[i].want);
            endcase
        end

        // Random part: one tap setting per phase, mostly steps with occasional reloads,
        // so the registers run long majority-clocked sequences between loads.
        for (setting = 0; setting < TAP_SETTINGS; setting++)
        begin
            drain_results();
            case (setting)
                0:
                begin
                    xf = TAP_FIRST_RESET;
                    xs = TAP_SECOND_RESET;
                    yf = TAP_FIRST_RESET;
                    ys = TAP_SECOND_RESET;
                    zf = TAP_FIRST_RESET;
                    zs = TAP_SECOND_RESET;
                end
                1:
                begin
                    xf = '0;
                    xs = '0;
                    yf = '0;
                    ys = '0;
                    zf = '0;
                    zs = '0;
                end
                2:
                begin
                    xf = TAP_BEYOND;
                    xs = TAP_BEYOND;
                    yf = TAP_BEYOND;
                    ys = TAP_BEYOND;
                    zf = TAP_BEYOND;
                    zs = TAP_BEYOND;
                end
                3:
                begin
                    xf = TAP_W'(LEN_X_DEFAULT - 1);
                    xs = '0;
                    yf = TAP_W'(LEN_Y_DEFAULT - 1);
                    ys = '0;
                    zf = TAP_W'(LEN_Z_DEFAULT - 1);
                    zs = '0;
                end
                default:
                begin
                    // The last two settings also allow taps outside the registers.
                    xf = pick_tap(LEN_X_DEFAULT, setting >= 6);
                    xs = pick_tap(LEN_X_DEFAULT, setting >= 6);
                    yf = pick_tap(LEN_Y_DEFAULT, setting >= 6);
                    ys = pick_tap(LEN_Y_DEFAULT, setting >= 6);
                    zf = pick_tap(LEN_Z_DEFAULT, setting >= 6);
                    zs = pick_tap(LEN_Z_DEFAULT, setting >= 6);
                end
            endcase
            write_tap(REG_X_TAP_FIRST, xf);
            write_tap(REG_X_TAP_SECOND, xs);
            write_tap(REG_Y_TAP_FIRST, yf);
            write_tap(REG_Y_TAP_SECOND, ys);
            write_tap(REG_Z_TAP_FIRST, zf);
            write_tap(REG_Z_TAP_SECOND, zs);
            if ($urandom_range(0, 1) != 0)
            begin
                rnd = $urandom();
                write_tap(rnd[0] ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO, rnd[5:1]);
            end

            burst_left = $urandom_range(1, 24);
            for (n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                // Long receiver hold while the sender keeps pushing without gaps.
                if (setting == 2 && n == 40)
                begin
                    hold_orders++;
                    steady_left = 2 * HOLD_CYCLES;
                end
                // Mid-phase pause until the block has handed back everything.
                if (setting == 5 && n == ITEMS_PER_SETTING / 2)
                    drain_results();

                rnd = $urandom();
                lx  = rnd[LOAD_X_W-1:0];
                rnd = $urandom();
                ly  = rnd[LOAD_Y_W-1:0];
                rnd = $urandom();
                lz  = rnd[LOAD_Z_W-1:0];
                if ($urandom_range(0, 7) == 0)
                begin
                    action = ACTION_LOAD;
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            lx = '0;
                            ly = '0;
                            lz = '0;
                        end
                        1:
                        begin
                            lx = X_ONES;
                            ly = Y_ONES;
                            lz = Z_ONES;
                        end
                        default:
                            ;
                    endcase
                end
                else
                begin
                    action = ACTION_STEP;
                    if ($urandom_range(0, 1) == 0)
                    begin
                        lx = '0;
                        ly = '0;
                        lz = '0;
                    end
                end
                offer(action, lx, ly, lz, 1'b0, '0);

                // The second setting runs with the sender never pausing.
                if (steady_left != 0)
                    steady_left--;
                else if (setting != 1)
                    pace();
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (keystream_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4)
            @(posedge clk);
        if (keystream_due.size() != 0)
        begin
            $display("%0d results never arrived", keystream_due.size());
            failures += keystream_due.size();
        end

        $display("Sent %0d loads, %0d steps, %0d tap settings and %0d tap writes.",
                 loads_sent, steps_sent, TAP_SETTINGS, tap_writes);
        $display("Checked %0d results, output held off once for %0d cycles, %0d failures.",
                 results_seen, HOLD_CYCLES, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mclk_pkg.sv
rtl/mclk_lfsr.sv
rtl/majority_clocked_lfsr_keystream_top.sv
test/tb_majority_clocked_lfsr_keystream_top.sv
